FILE: sv/psvp_pkg.sv
// ----------------------------------------------------------------------------
// psvp_pkg
// Shared types, constants and tables of the point source visibility predictor.
// ----------------------------------------------------------------------------
package psvp_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int CW = 34;                 // CORDIC datapath width
  localparam int OPW = 36;                // shared multiplier operand width
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  // ceil(2^31 / 45), exact quotient for magnitudes below 2^26
  localparam logic [25:0] RECIP45 = 26'd47721859;

  localparam logic [1:0] TAG_DEC  = 2'd0;
  localparam logic [1:0] TAG_PDEC = 2'd1;
  localparam logic [1:0] TAG_RA   = 2'd2;
  localparam logic [1:0] TAG_PH   = 2'd3;

  localparam logic [2:0] REG_PRA  = 3'd0;
  localparam logic [2:0] REG_PDEC = 3'd4;

  typedef struct packed {
    logic              valid;
    logic [1:0]        tag;
    logic signed [25:0] d;
  } deg_req_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  tag;
    logic [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           tag;
    logic signed [CW-1:0] cos_v;
    logic signed [CW-1:0] sin_v;
  } cordic_rsp_t;

  typedef struct packed {
    logic                 valid;
    logic                 flip;
    logic [1:0]           tag;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cell_t;

  // arctangent of 2^-i in turns * 2^32
  function automatic logic [31:0] atan_turns(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'd536870912;   1: r = 32'd316933406;   2: r = 32'd167458907;
      3: r = 32'd85004756;    4: r = 32'd42667331;    5: r = 32'd21354465;
      6: r = 32'd10679838;    7: r = 32'd5340245;     8: r = 32'd2670163;
      9: r = 32'd1335087;     10: r = 32'd667544;     11: r = 32'd333772;
      12: r = 32'd166886;     13: r = 32'd83443;      14: r = 32'd41722;
      15: r = 32'd20861;      16: r = 32'd10430;      17: r = 32'd5215;
      18: r = 32'd2608;       19: r = 32'd1304;       20: r = 32'd652;
      21: r = 32'd326;        22: r = 32'd163;        23: r = 32'd81;
      24: r = 32'd41;         25: r = 32'd20;         26: r = 32'd10;
      27: r = 32'd5;          28: r = 32'd3;          29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // floor((b * 8192 + 22) / 45) for a remainder b of a division by 45
  function automatic logic [12:0] rem45_turns(input logic [5:0] b);
    logic [12:0] r;
    case (b)
      6'd0: r = 13'd0;       6'd1: r = 13'd182;     6'd2: r = 13'd364;
      6'd3: r = 13'd546;     6'd4: r = 13'd728;     6'd5: r = 13'd910;
      6'd6: r = 13'd1092;    6'd7: r = 13'd1274;    6'd8: r = 13'd1456;
      6'd9: r = 13'd1638;    6'd10: r = 13'd1820;   6'd11: r = 13'd2002;
      6'd12: r = 13'd2185;   6'd13: r = 13'd2367;   6'd14: r = 13'd2549;
      6'd15: r = 13'd2731;   6'd16: r = 13'd2913;   6'd17: r = 13'd3095;
      6'd18: r = 13'd3277;   6'd19: r = 13'd3459;   6'd20: r = 13'd3641;
      6'd21: r = 13'd3823;   6'd22: r = 13'd4005;   6'd23: r = 13'd4187;
      6'd24: r = 13'd4369;   6'd25: r = 13'd4551;   6'd26: r = 13'd4733;
      6'd27: r = 13'd4915;   6'd28: r = 13'd5097;   6'd29: r = 13'd5279;
      6'd30: r = 13'd5461;   6'd31: r = 13'd5643;   6'd32: r = 13'd5825;
      6'd33: r = 13'd6007;   6'd34: r = 13'd6190;   6'd35: r = 13'd6372;
      6'd36: r = 13'd6554;   6'd37: r = 13'd6736;   6'd38: r = 13'd6918;
      6'd39: r = 13'd7100;   6'd40: r = 13'd7282;   6'd41: r = 13'd7464;
      6'd42: r = 13'd7646;   6'd43: r = 13'd7828;   6'd44: r = 13'd8010;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/psvp_if.sv
// ----------------------------------------------------------------------------
// psvp_if
// Request channels of the visibility predictor: source in, visibility out.
// ----------------------------------------------------------------------------
interface psvp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] baseline_u;
  logic signed [31:0] baseline_v;
  logic signed [31:0] baseline_w;
  logic [24:0]        src_ra;
  logic signed [23:0] src_dec;
  logic [31:0]        src_flux;
  logic               last_source;

  modport source (output valid, baseline_u, baseline_v, baseline_w, src_ra, src_dec,
                  src_flux, last_source, input ready);
  modport sink (input valid, baseline_u, baseline_v, baseline_w, src_ra, src_dec,
                src_flux, last_source, output ready);
endinterface

interface psvp_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] vis_re;
  logic signed [39:0] vis_im;

  modport source (output valid, vis_re, vis_im, input ready);
  modport sink (input valid, vis_re, vis_im, output ready);
endinterface

FILE: sv/psvp_deg2turn.sv
// ----------------------------------------------------------------------------
// psvp_deg2turn
// Degrees * 2^16 to turns * 2^32, rounded half away from zero, two stages.
// ----------------------------------------------------------------------------
module psvp_deg2turn (
  input  logic                   clk,
  input  logic                   rst,
  input  psvp_pkg::deg_req_t     req,
  output psvp_pkg::cordic_req_t  rsp
);

  logic        v1;
  logic [1:0]  tag1;
  logic        neg1;
  logic [25:0] mag1;
  logic [51:0] prod1;
  logic [25:0] mag0;
  logic [20:0] quo;
  logic [26:0] rem;
  logic [33:0] q;

  assign mag0 = req.d[25] ? 26'(-req.d) : 26'(req.d);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      v1 <= req.valid;
      rsp.valid <= v1;
    end
    tag1  <= req.tag;
    neg1  <= req.d[25];
    mag1  <= mag0;
    prod1 <= 52'(mag0) * 52'(psvp_pkg::RECIP45);
    rsp.tag <= tag1;
    rsp.angle <= neg1 ? 32'(-q) : q[31:0];
  end

  // d = 45*quo + rem; result = quo*8192 + table(rem)
  always_comb begin
    quo = prod1[51:31];
    rem = {1'b0, mag1} - ({6'b0, quo} * 27'd45);
    q   = {quo, 13'b0} + {21'b0, psvp_pkg::rem45_turns(rem[5:0])};
  end

endmodule

FILE: sv/psvp_cordic_cell.sv
// ----------------------------------------------------------------------------
// psvp_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module psvp_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  psvp_pkg::cell_t  din,
  output psvp_pkg::cell_t  dout
);

  localparam logic signed [psvp_pkg::CW-1:0] ATAN =
    psvp_pkg::CW'(psvp_pkg::atan_turns(IDX));

  logic signed [psvp_pkg::CW-1:0] dx;
  logic signed [psvp_pkg::CW-1:0] dy;

  assign dx = din.y >>> IDX;
  assign dy = din.x >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.flip <= din.flip;
    dout.tag  <= din.tag;
    if (!din.z[psvp_pkg::CW-1]) begin
      dout.x <= din.x - dx;
      dout.y <= din.y + dy;
      dout.z <= din.z - ATAN;
    end else begin
      dout.x <= din.x + dx;
      dout.y <= din.y - dy;
      dout.z <= din.z + ATAN;
    end
  end

endmodule

FILE: sv/psvp_cordic.sv
// ----------------------------------------------------------------------------
// psvp_cordic
// Sine/cosine chain: quarter-turn fold, STAGES cells, sign restore.
// ----------------------------------------------------------------------------
module psvp_cordic #(
  parameter int STAGES = psvp_pkg::CORDIC_STAGES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  psvp_pkg::cordic_req_t req,
  output psvp_pkg::cordic_rsp_t rsp
);

  psvp_pkg::cell_t chain [0:STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid <= req.valid;
    end
    // angles nearer the half turn rotate by a half turn and negate at the end
    chain[0].flip <= req.angle[31] ^ req.angle[30];
    chain[0].tag  <= req.tag;
    chain[0].x    <= psvp_pkg::CORDIC_X0;
    chain[0].y    <= '0;
    if (req.angle[31] ^ req.angle[30]) begin
      chain[0].z <= psvp_pkg::CW'($signed({~req.angle[31], req.angle[30:0]}));
    end else begin
      chain[0].z <= psvp_pkg::CW'($signed(req.angle));
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    psvp_cordic_cell #(.IDX(i)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= chain[STAGES].valid;
    end
    rsp.tag   <= chain[STAGES].tag;
    rsp.cos_v <= chain[STAGES].flip ? -chain[STAGES].x : chain[STAGES].x;
    rsp.sin_v <= chain[STAGES].flip ? -chain[STAGES].y : chain[STAGES].y;
  end

endmodule

FILE: sv/psvp_sqrt.sv
// ----------------------------------------------------------------------------
// psvp_sqrt
// Floor square root of a 64-bit value, shift-subtract, one bit per cycle.
// ----------------------------------------------------------------------------
module psvp_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] r;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [5:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      r    <= value;
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (r >= trial) begin
        r   <= r - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

FILE: sv/point_source_visibility_predict.sv
// ----------------------------------------------------------------------------
// point_source_visibility_predict
// Direct Fourier visibility prediction of point sources on one baseline.
// ----------------------------------------------------------------------------
// A source passes the angle conversion and the CORDIC cell chain, then the
//   multiplier steps and the root, which is skipped when the source lies on
//   or beyond the horizon (no root), and then the CORDIC cell chain once more.
// Sources are taken one at a time: a new one is accepted only in idle.
// The result of a last source waits in an output register; the next source
//   is taken meanwhile. Reset (synchronous) clears pointing and sums to 0.
module point_source_visibility_predict #(
  parameter int CORDIC_STAGES = psvp_pkg::CORDIC_STAGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  psvp_in_if.sink     in_ch,
  psvp_out_if.source  out_ch
);

  localparam int OPW = psvp_pkg::OPW;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_ISSUE = 5'd1;
  localparam logic [4:0] ST_WAITC = 5'd2;
  localparam logic [4:0] ST_M1    = 5'd3;
  localparam logic [4:0] ST_M2    = 5'd4;
  localparam logic [4:0] ST_M3    = 5'd5;
  localparam logic [4:0] ST_M4    = 5'd6;
  localparam logic [4:0] ST_M5    = 5'd7;
  localparam logic [4:0] ST_M6    = 5'd8;
  localparam logic [4:0] ST_M7    = 5'd9;
  localparam logic [4:0] ST_SQ0   = 5'd10;
  localparam logic [4:0] ST_SQ    = 5'd11;
  localparam logic [4:0] ST_P1    = 5'd12;
  localparam logic [4:0] ST_P2    = 5'd13;
  localparam logic [4:0] ST_P3    = 5'd14;
  localparam logic [4:0] ST_P4    = 5'd15;
  localparam logic [4:0] ST_P5    = 5'd16;
  localparam logic [4:0] ST_WAITP = 5'd17;
  localparam logic [4:0] ST_R1    = 5'd18;
  localparam logic [4:0] ST_R2    = 5'd19;
  localparam logic [4:0] ST_R3    = 5'd20;
  localparam logic [4:0] ST_EMIT  = 5'd21;

  localparam logic signed [41:0] SUM_MAX = 42'sd549755813887;
  localparam logic signed [41:0] SUM_MIN = -42'sd549755813888;
  localparam logic signed [65:0] ONE_Q60 = 66'sd1 <<< 60;
  localparam logic signed [OPW-1:0] ONE_Q30 = OPW'(1) <<< 30;

  // configuration
  logic [24:0]        pointing_ra;
  logic signed [23:0] pointing_dec;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {{8{pointing_dec[23]}}, pointing_dec} : {7'b0, pointing_ra};

  always_ff @(posedge clk) begin
    if (rst) begin
      pointing_ra  <= '0;
      pointing_dec <= '0;
    end else if (psel && penable && pwrite) begin
      case ({paddr[2], 2'b00})
        psvp_pkg::REG_PRA:  pointing_ra  <= pwdata[24:0];
        psvp_pkg::REG_PDEC: pointing_dec <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // request latch
  logic [4:0]         state;
  logic [1:0]         issue_cnt;
  logic signed [31:0] u_q, v_q, w_q;
  logic [24:0]        ra_q;
  logic signed [23:0] dec_q;
  logic [31:0]        flux_q;
  logic               last_q;

  assign in_ch.ready = (state == ST_IDLE);

  // angle conversion and CORDIC chain
  psvp_pkg::deg_req_t    deg_req;
  psvp_pkg::cordic_req_t conv_rsp;
  psvp_pkg::cordic_req_t ph_req;
  psvp_pkg::cordic_req_t cor_req;
  psvp_pkg::cordic_rsp_t cor_rsp;

  always_comb begin
    deg_req.valid = (state == ST_ISSUE);
    case (issue_cnt)
      2'd0: begin
        deg_req.tag = psvp_pkg::TAG_DEC;
        deg_req.d   = 26'(dec_q);
      end
      2'd1: begin
        deg_req.tag = psvp_pkg::TAG_PDEC;
        deg_req.d   = 26'(pointing_dec);
      end
      default: begin
        deg_req.tag = psvp_pkg::TAG_RA;
        deg_req.d   = $signed({1'b0, ra_q}) - $signed({1'b0, pointing_ra});
      end
    endcase
  end

  psvp_deg2turn u_deg2turn (
    .clk (clk),
    .rst (rst),
    .req (deg_req),
    .rsp (conv_rsp)
  );

  assign cor_req = conv_rsp.valid ? conv_rsp : ph_req;

  psvp_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cor_req),
    .rsp (cor_rsp)
  );

  logic signed [psvp_pkg::CW-1:0] cd, sd, cd0, sd0, cr, sr, ct, st;

  always_ff @(posedge clk) begin
    if (cor_rsp.valid) begin
      case (cor_rsp.tag)
        psvp_pkg::TAG_DEC:  begin cd  <= cor_rsp.cos_v; sd  <= cor_rsp.sin_v; end
        psvp_pkg::TAG_PDEC: begin cd0 <= cor_rsp.cos_v; sd0 <= cor_rsp.sin_v; end
        psvp_pkg::TAG_RA:   begin cr  <= cor_rsp.cos_v; sr  <= cor_rsp.sin_v; end
        default:            begin ct  <= cor_rsp.cos_v; st  <= cor_rsp.sin_v; end
      endcase
    end
  end

  // shared multiplier, product registered
  logic signed [OPW-1:0]   op_a, op_b;
  logic signed [2*OPW-1:0] prod;
  logic signed [OPW-1:0]   prod_q30;
  logic signed [OPW-1:0]   l, m, t1, amp;
  logic signed [65:0]      l2, rem;
  logic [30:0]             n;
  logic [63:0]             ph, ph_sum;

  assign prod_q30 = OPW'(prod >>> 30);
  assign ph_sum   = ph + prod[63:0];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      ST_M1: begin op_a = OPW'(cd); op_b = OPW'(sr); end
      ST_M2: begin op_a = OPW'(sd); op_b = OPW'(cd0); end
      ST_M3: begin op_a = OPW'(cd); op_b = OPW'(sd0); end
      ST_M4: begin op_a = prod_q30; op_b = OPW'(cr); end
      ST_M5: begin op_a = l; op_b = l; end
      ST_M6: begin op_a = m; op_b = m; end
      ST_P1: begin op_a = OPW'(u_q); op_b = l; end
      ST_P2: begin op_a = OPW'(v_q); op_b = m; end
      ST_P3: begin op_a = OPW'(w_q); op_b = $signed({5'b0, n}) - ONE_Q30; end
      ST_P4: begin op_a = $signed({4'b0, flux_q}); op_b = $signed({5'b0, n}); end
      ST_R1: begin op_a = amp; op_b = OPW'(ct); end
      ST_R2: begin op_a = amp; op_b = OPW'(st); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  always_comb begin
    ph_req.valid = (state == ST_P4);
    ph_req.tag   = psvp_pkg::TAG_PH;
    ph_req.angle = ph_sum[37:6];
  end

  // square root
  logic        sq_start, sq_done;
  logic [31:0] sq_root;

  assign sq_start = (state == ST_SQ0) && (rem > 66'sd0);

  psvp_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (rem[63:0]),
    .done  (sq_done),
    .root  (sq_root)
  );

  // accumulation
  logic signed [39:0] sum_re, sum_im;
  logic signed [41:0] acc_next;
  logic signed [39:0] acc_sat;
  logic               out_free;

  assign out_free = !out_ch.valid || out_ch.ready;

  always_comb begin
    if (state == ST_R2) acc_next = 42'(sum_re) + 42'(prod_q30);
    else acc_next = 42'(sum_im) + 42'(prod_q30);
    if (acc_next > SUM_MAX) acc_sat = SUM_MAX[39:0];
    else if (acc_next < SUM_MIN) acc_sat = SUM_MIN[39:0];
    else acc_sat = acc_next[39:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      issue_cnt    <= '0;
      sum_re       <= '0;
      sum_im       <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      // a new result in the same cycle keeps valid high
      if (out_ch.valid && out_ch.ready && !(state == ST_EMIT && last_q))
        out_ch.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            state     <= ST_ISSUE;
            issue_cnt <= '0;
          end
        end
        ST_ISSUE: begin
          issue_cnt <= issue_cnt + 2'd1;
          if (issue_cnt == 2'd2) state <= ST_WAITC;
        end
        ST_WAITC: if (cor_rsp.valid && cor_rsp.tag == psvp_pkg::TAG_RA) state <= ST_M1;
        ST_M1: state <= ST_M2;
        ST_M2: state <= ST_M3;
        ST_M3: state <= ST_M4;
        ST_M4: state <= ST_M5;
        ST_M5: state <= ST_M6;
        ST_M6: state <= ST_M7;
        ST_M7: state <= ST_SQ0;
        ST_SQ0: state <= (rem > 66'sd0) ? ST_SQ : ST_P1;
        ST_SQ: if (sq_done) state <= ST_P1;
        ST_P1: state <= ST_P2;
        ST_P2: state <= ST_P3;
        ST_P3: state <= ST_P4;
        ST_P4: state <= ST_P5;
        ST_P5: state <= ST_WAITP;
        ST_WAITP: if (cor_rsp.valid && cor_rsp.tag == psvp_pkg::TAG_PH) state <= ST_R1;
        ST_R1: state <= ST_R2;
        ST_R2: begin
          sum_re <= acc_sat;
          state  <= ST_R3;
        end
        ST_R3: begin
          sum_im <= acc_sat;
          state  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!last_q) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_ch.valid <= 1'b1;
            sum_re       <= '0;
            sum_im       <= '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_ch.valid) begin
      u_q    <= in_ch.baseline_u;
      v_q    <= in_ch.baseline_v;
      w_q    <= in_ch.baseline_w;
      ra_q   <= in_ch.src_ra;
      dec_q  <= in_ch.src_dec;
      flux_q <= in_ch.src_flux;
      last_q <= in_ch.last_source;
    end
    case (state)
      ST_M2: l   <= prod_q30;
      ST_M3: t1  <= prod_q30;
      ST_M5: m   <= t1 - prod_q30;
      ST_M6: l2  <= prod[65:0];
      ST_M7: rem <= ONE_Q60 - l2 - prod[65:0];
      ST_SQ0: n  <= '0;
      ST_SQ: if (sq_done) n <= sq_root[30:0];
      ST_P2: ph  <= prod[63:0];
      ST_P3: ph  <= ph_sum;
      ST_P5: amp <= prod_q30;
      default: ;
    endcase
    if (state == ST_EMIT && last_q && out_free) begin
      out_ch.vis_re <= sum_re;
      out_ch.vis_im <= sum_im;
    end
  end

  a_sqrt_in_wait: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == ST_SQ))
    else $error("root finished outside its wait state");

  a_phase_in_wait: assert property (@(posedge clk) disable iff (rst)
    (cor_rsp.valid && cor_rsp.tag == psvp_pkg::TAG_PH) |-> (state == ST_WAITP))
    else $error("phase rotation returned outside its wait state");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && last_q && out_free)
      |=> (out_ch.valid && sum_re == 40'sd0 && sum_im == 40'sd0))
    else $error("emitted sum not cleared");

  a_no_chain_clash: assert property (@(posedge clk) disable iff (rst)
    !(conv_rsp.valid && ph_req.valid))
    else $error("two requests into the CORDIC chain at once");

endmodule
